@@ rtl/core/htl_pkg.sv @@
// ----------------------------------------------------------------------------
// htl_pkg
// Shared constants, register codes and reset values for the humidity and
// temperature linearizer.
// ----------------------------------------------------------------------------
package htl_pkg;

  localparam int HUM_BITS_DEF  = 12;
  localparam int TEMP_BITS_DEF = 14;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 38;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIN_OFFSET   = 3'd0,
    REG_LIN_SLOPE    = 3'd1,
    REG_LIN_SQUARE   = 3'd2,
    REG_TEMP_OFFSET  = 3'd3,
    REG_CLAMP_ENABLE = 3'd4
  } cfg_reg_t;

  // register widths
  localparam int OFFSET_W = 38;
  localparam int SLOPE_W  = 30;
  localparam int SQUARE_W = 21;
  localparam int TOFF_W   = 14;

  // register reset values
  localparam logic signed [OFFSET_W-1:0] OFFSET_RST = -38'sd20468000000;
  localparam logic        [SLOPE_W-1:0]  SLOPE_RST  = 30'd367000000;
  localparam logic signed [SQUARE_W-1:0] SQUARE_RST = -21'sd15955;
  localparam logic        [TOFF_W-1:0]   TOFF_RST   = 14'd3970;
  localparam logic                       CLAMP_RST  = 1'b1;

  // word widths
  localparam int TEMP_W = 15;
  localparam int HUM_W  = 16;
  localparam int SUM_W  = 48;

  // temperature compensation term
  localparam int TEMP_REF  = 2500;
  localparam int RH_BIAS   = 125;
  localparam int TEMP_GAIN = 8000;
  localparam int TDIFF_W   = 16;

  // rounding and scaling by 1e8 = 2^8 * 390625
  localparam int                     ROUND_HALF  = 50000000;
  localparam logic [SUM_W-1:0]       SAT_LIMIT   = 48'd3276900000000;
  localparam int                     DIV_SHIFT   = 8;
  localparam int                     Y_W         = 34;
  localparam int                     Y_LO_W      = 32;
  localparam int                     DIV_ODD     = 390625;
  localparam int                     RECIP_W     = 32;
  localparam logic [RECIP_W-1:0]     RECIP       = 32'd2882303761;
  localparam int                     RECIP_SHIFT = 50;
  localparam int                     Q_W         = 16;

  // output limits
  localparam int HS_W      = 18;
  localparam int SAT_MAG   = 32769;
  localparam int CLAMP_LO  = 10;
  localparam int CLAMP_HI  = 10000;
  localparam int HUM_MAX   = 32767;
  localparam int HUM_MIN   = -32768;

  localparam int PIPE_DEPTH = 11;

endpackage

@@ rtl/core/humidity_temperature_linearizer.sv @@
// ----------------------------------------------------------------------------
// humidity_temperature_linearizer
// Converts raw humidity and temperature readings into hundredths of %RH and
// hundredths of a degree, with second-order linearization and temperature
// compensation of humidity.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while no result is stalled; the eleven-stage
//   datapath, with the 1e8 scaling done as a split reciprocal multiply, takes
//   a word every clock unless the pipeline is frozen.
// A stalled result freezes the whole pipeline and holds reading_stall high.
// Reset clears all valid bits and loads the default coefficients.
// ----------------------------------------------------------------------------
module humidity_temperature_linearizer #(
  parameter int HUMIDITY_BITS    = htl_pkg::HUM_BITS_DEF,
  parameter int TEMPERATURE_BITS = htl_pkg::TEMP_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [htl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [htl_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                reading_valid,
  output logic                                reading_stall,
  input  logic [HUMIDITY_BITS-1:0]            humidity_ticks,
  input  logic [TEMPERATURE_BITS-1:0]         temperature_ticks,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [htl_pkg::TEMP_W-1:0]   temperature_centi,
  output logic signed [htl_pkg::HUM_W-1:0]    humidity_centi
);

  import htl_pkg::*;

  localparam int LIN_W = SLOPE_W + HUMIDITY_BITS;
  localparam int RH2_W = 2 * HUMIDITY_BITS;
  localparam int RHB_W = HUMIDITY_BITS + 1;
  localparam int TM_W  = TDIFF_W + RHB_W + 1;
  localparam int SQ_W  = SQUARE_W + RH2_W + 1;
  localparam int TT_W  = TM_W + 14;
  localparam int PLO_W = Y_LO_W + RECIP_W;
  localparam int PHI_W = Y_W - Y_LO_W + RECIP_W;
  localparam int PF_W  = Y_W + RECIP_W;

  // configuration registers
  logic signed [OFFSET_W-1:0] lin_offset;
  logic        [SLOPE_W-1:0]  lin_slope;
  logic signed [SQUARE_W-1:0] lin_square;
  logic        [TOFF_W-1:0]   temp_offset;
  logic                       clamp_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      lin_offset   <= OFFSET_RST;
      lin_slope    <= SLOPE_RST;
      lin_square   <= SQUARE_RST;
      temp_offset  <= TOFF_RST;
      clamp_enable <= CLAMP_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LIN_OFFSET:   lin_offset   <= cfg_data[OFFSET_W-1:0];
        REG_LIN_SLOPE:    lin_slope    <= cfg_data[SLOPE_W-1:0];
        REG_LIN_SQUARE:   lin_square   <= cfg_data[SQUARE_W-1:0];
        REG_TEMP_OFFSET:  temp_offset  <= cfg_data[TOFF_W-1:0];
        REG_CLAMP_ENABLE: clamp_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [PIPE_DEPTH:1] vld;
  logic                adv;
  logic                accept;

  assign adv           = !(vld[PIPE_DEPTH] && result_stall);
  assign reading_stall = !adv;
  assign accept        = reading_valid && adv;
  assign result_valid  = vld[PIPE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-1:1], accept};
    end
  end

  // datapath registers
  logic signed [TEMP_W-1:0]  tc_pipe [1:PIPE_DEPTH];
  logic [HUMIDITY_BITS-1:0]  s1_rh;
  logic [LIN_W-1:0]          s1_lin, s2_lin;
  logic [RH2_W-1:0]          s2_rh2;
  logic signed [TM_W-1:0]    s2_tm;
  logic signed [SQ_W-1:0]    s3_sq;
  logic signed [TT_W-1:0]    s3_tt;
  logic signed [SUM_W-1:0]   s3_base, s4_sum;
  logic [SUM_W-1:0]          s5_abs;
  logic                      s5_neg, s6_neg, s7_neg, s8_neg, s9_neg, s10_neg;
  logic                      s6_sat, s7_sat, s8_sat, s9_sat, s10_sat;
  logic [Y_W-1:0]            s6_y, s7_y, s8_y, s9_y;
  logic [PLO_W-1:0]          s7_plo;
  logic [PHI_W-1:0]          s7_phi;
  logic [Q_W-1:0]            s8_qe, s9_qe, s10_q;
  logic [Y_W-1:0]            s9_qd;
  logic signed [HUM_W-1:0]   hum;

  // stage logic
  logic signed [TEMP_W-1:0]  tc_next;
  logic [LIN_W-1:0]          lin_next;
  logic signed [TDIFF_W-1:0] tdiff;
  logic [RHB_W-1:0]          rhb;
  logic signed [TM_W-1:0]    tm_next;
  logic [RH2_W-1:0]          rh2_next;
  logic signed [SQ_W-1:0]    sq_next;
  logic signed [TT_W-1:0]    tt_next;
  logic signed [SUM_W-1:0]   base_next, sum_next;
  logic [SUM_W-1:0]          abs_next, rnd;
  logic                      sat_next;
  logic [Y_W-1:0]            y_next;
  logic [PLO_W-1:0]          plo_next;
  logic [PHI_W-1:0]          phi_next;
  logic [PF_W-1:0]           pfull;
  logic [Q_W-1:0]            qe_next, q_next;
  logic [Y_W-1:0]            qd_next, rem;
  logic signed [HS_W-1:0]    mag, hs;
  logic signed [HUM_W-1:0]   hum_next;

  always_comb begin
    tc_next  = TEMP_W'(temperature_ticks) - TEMP_W'(temp_offset);
    lin_next = LIN_W'(lin_slope) * LIN_W'(humidity_ticks);

    tdiff    = TDIFF_W'(tc_pipe[1]) - TDIFF_W'(TEMP_REF);
    rhb      = RHB_W'(s1_rh) + RHB_W'(RH_BIAS);
    tm_next  = TM_W'(tdiff) * TM_W'(signed'({1'b0, rhb}));
    rh2_next = RH2_W'(s1_rh) * RH2_W'(s1_rh);

    sq_next   = SQ_W'(lin_square) * SQ_W'(signed'({1'b0, s2_rh2}));
    tt_next   = TT_W'(s2_tm) * TT_W'(TEMP_GAIN);
    base_next = SUM_W'(lin_offset) + SUM_W'(signed'({1'b0, s2_lin}));

    sum_next = s3_base + SUM_W'(s3_sq) + SUM_W'(s3_tt);

    abs_next = s4_sum[SUM_W-1] ? SUM_W'(-s4_sum) : SUM_W'(s4_sum);

    rnd      = s5_abs + SUM_W'(ROUND_HALF);
    sat_next = rnd >= SAT_LIMIT;
    y_next   = rnd[DIV_SHIFT +: Y_W];

    plo_next = PLO_W'(s6_y[Y_LO_W-1:0]) * PLO_W'(RECIP);
    phi_next = PHI_W'(s6_y[Y_W-1:Y_LO_W]) * PHI_W'(RECIP);

    pfull   = PF_W'(s7_plo) + (PF_W'(s7_phi) << Y_LO_W);
    qe_next = pfull[RECIP_SHIFT +: Q_W];

    qd_next = Y_W'(Y_W'(s8_qe) * Y_W'(DIV_ODD));

    rem    = s9_y - s9_qd;
    q_next = s9_qe + Q_W'(rem >= Y_W'(DIV_ODD));

    mag = s10_sat ? HS_W'(SAT_MAG) : HS_W'(signed'({1'b0, s10_q}));
    hs  = s10_neg ? -mag : mag;
    if (clamp_enable) begin
      if (hs > HS_W'(CLAMP_HI)) begin
        hs = HS_W'(CLAMP_HI);
      end else if (hs < HS_W'(CLAMP_LO)) begin
        hs = HS_W'(CLAMP_LO);
      end
    end
    priority if (hs > HS_W'(HUM_MAX)) begin
      hum_next = HUM_W'(HUM_MAX);
    end else if (hs < HS_W'(HUM_MIN)) begin
      hum_next = HUM_W'(HUM_MIN);
    end else begin
      hum_next = hs[HUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tc_pipe[1] <= tc_next;
      for (int i = 2; i <= PIPE_DEPTH; i++) begin
        tc_pipe[i] <= tc_pipe[i-1];
      end
      s1_rh   <= humidity_ticks;
      s1_lin  <= lin_next;
      s2_rh2  <= rh2_next;
      s2_tm   <= tm_next;
      s2_lin  <= s1_lin;
      s3_sq   <= sq_next;
      s3_tt   <= tt_next;
      s3_base <= base_next;
      s4_sum  <= sum_next;
      s5_neg  <= s4_sum[SUM_W-1];
      s5_abs  <= abs_next;
      s6_neg  <= s5_neg;
      s6_sat  <= sat_next;
      s6_y    <= y_next;
      s7_neg  <= s6_neg;
      s7_sat  <= s6_sat;
      s7_y    <= s6_y;
      s7_plo  <= plo_next;
      s7_phi  <= phi_next;
      s8_neg  <= s7_neg;
      s8_sat  <= s7_sat;
      s8_y    <= s7_y;
      s8_qe   <= qe_next;
      s9_neg  <= s8_neg;
      s9_sat  <= s8_sat;
      s9_y    <= s8_y;
      s9_qe   <= s8_qe;
      s9_qd   <= qd_next;
      s10_neg <= s9_neg;
      s10_sat <= s9_sat;
      s10_q   <= q_next;
      hum     <= hum_next;
    end
  end

  assign temperature_centi = tc_pipe[PIPE_DEPTH];
  assign humidity_centi    = hum;

  // checks
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result word valid after reset");

  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && clamp_enable) |->
      (humidity_centi >= HUM_W'(CLAMP_LO) && humidity_centi <= HUM_W'(CLAMP_HI)))
    else $error("clamped humidity out of range");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> $stable(vld))
    else $error("pipeline moved during output stall");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> temperature_centi != TEMP_W'(-16384))
    else $error("temperature word out of range");

endmodule

@@ bench/humidity_temperature_linearizer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// humidity_temperature_linearizer_test
// Self-checking bench for the humidity and temperature linearizer. Readings
// are queued by the stimulus process and offered by a clocked sender with
// random gaps. Results are taken by a receiver that stalls at random and
// once holds off long enough to back the pipeline up. Every result word is
// compared against an integer evaluation of the linearization under the
// coefficient set that was loaded. Coefficient sets run from the defaults
// through both sensor variants, range extremes, rounding ties and raw
// full-width register values.
// ----------------------------------------------------------------------------
module humidity_temperature_linearizer_test;
  import htl_pkg::*;

  localparam int RH_W = HUM_BITS_DEF;
  localparam int T_W  = TEMP_BITS_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam longint ROUND_STEP = 64'sd100000000;
  localparam longint ROUND_TIE  = 64'sd50000000;

  typedef struct packed {
    logic [RH_W-1:0] rh;
    logic [T_W-1:0]  t;
  } reading_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic signed [HUM_W-1:0]  hum;
  } conversion_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    reading_valid = 1'b0;
  logic                    reading_stall;
  logic [RH_W-1:0]         humidity_ticks = '0;
  logic [T_W-1:0]          temperature_ticks = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic signed [HUM_W-1:0]  humidity_centi;

  humidity_temperature_linearizer dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .reading_valid     (reading_valid),
    .reading_stall     (reading_stall),
    .humidity_ticks    (humidity_ticks),
    .temperature_ticks (temperature_ticks),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi)
  );

  // coefficient copy used for prediction
  logic signed [OFFSET_W-1:0] coef_offset = OFFSET_RST;
  logic [SLOPE_W-1:0]         coef_slope  = SLOPE_RST;
  logic signed [SQUARE_W-1:0] coef_square = SQUARE_RST;
  logic [TOFF_W-1:0]          temp_zero   = TOFF_RST;
  logic                       clamp_on    = CLAMP_RST;

  reading_t    pending_readings[$];
  conversion_t expected_conversions[$];

  int errors = 0;
  int readings_queued = 0;
  int readings_taken = 0;
  int results_seen = 0;
  int limited_words = 0;
  int sets_loaded = 0;
  logic reading_taken = 1'b0;

  int gap_left = 0;
  int send_rate = 0;
  int readings_sent = 0;
  int stall_left = 0;
  int stall_rate = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int rx_cycles = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic conversion_t linearize(logic [RH_W-1:0] rh_raw, logic [T_W-1:0] t_raw);
    conversion_t res;
    longint rh, tc, acc, h, h0;
    rh  = longint'(rh_raw);
    tc  = longint'(t_raw) - longint'(temp_zero);
    acc = longint'(coef_offset) + longint'(coef_slope) * rh
        + longint'(coef_square) * rh * rh
        + 64'sd8000 * (tc - 64'sd2500) * (64'sd125 + rh);
    if (acc >= 0) h = (acc + ROUND_TIE) / ROUND_STEP;
    else h = -((-acc + ROUND_TIE) / ROUND_STEP);
    h0 = h;
    if (clamp_on) begin
      if (h > 10000) h = 10000;
      if (h < 10) h = 10;
    end
    if (h > 32767) h = 32767;
    if (h < -32768) h = -32768;
    if (h != h0) limited_words++;
    res.temp = tc[TEMP_W-1:0];
    res.hum  = h[HUM_W-1:0];
    return res;
  endfunction

  function automatic int pick_rate();
    case ($urandom_range(2))
      0: return 0;
      1: return 15;
      default: return 50;
    endcase
  endfunction

  function automatic int pause_length();
    if ($urandom_range(9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // sender
  always @(negedge clk) begin : sender
    reading_t next_word;
    if (rst) begin
      reading_valid <= 1'b0;
    end else if (!(reading_valid && !reading_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        reading_valid <= 1'b0;
      end else if (pending_readings.size() > 0) begin
        next_word = pending_readings.pop_front();
        reading_valid     <= 1'b1;
        humidity_ticks    <= next_word.rh;
        temperature_ticks <= next_word.t;
        readings_sent++;
        if (readings_sent % 100 == 0) send_rate = pick_rate();
        if ($urandom_range(99) < send_rate) gap_left = pause_length();
      end else begin
        reading_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off to fill the pipeline
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles % 128 == 0) stall_rate = pick_rate();
      if (!hold_done && readings_taken >= 500) begin
        hold_done = 1'b1;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if ($urandom_range(99) < stall_rate) begin
        stall_left = pause_length() - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin : monitor
    conversion_t want;
    if (rst) begin
      reading_taken <= 1'b0;
    end else begin
      reading_taken <= reading_valid && !reading_stall;
      if (result_valid && !result_stall) begin
        results_seen++;
        if (expected_conversions.size() == 0) begin
          $error("result word with no reading outstanding");
          errors++;
        end else begin
          want = expected_conversions.pop_front();
          if (temperature_centi !== want.temp) begin
            $error("temperature_centi: expected %0d, got %0d", want.temp, temperature_centi);
            errors++;
          end
          if (humidity_centi !== want.hum) begin
            $error("humidity_centi: expected %0d, got %0d", want.hum, humidity_centi);
            errors++;
          end
        end
      end
      if (reading_valid && !reading_stall) begin
        expected_conversions.push_back(linearize(humidity_ticks, temperature_ticks));
        readings_taken++;
      end
    end
  end

  function automatic void add_reading(logic [RH_W-1:0] rh, logic [T_W-1:0] t);
    reading_t w;
    w.rh = rh;
    w.t  = t;
    pending_readings.push_back(w);
    readings_queued++;
  endfunction

  function automatic void add_random_reading();
    logic [RH_W-1:0] rh;
    logic [T_W-1:0]  t;
    rh = RH_W'($urandom_range(0, 4095));
    if ($urandom_range(7) == 0) rh = $urandom_range(1) ? '1 : '0;
    if ($urandom_range(1)) t = T_W'($urandom_range(3000, 11000));
    else t = T_W'($urandom_range(0, 16383));
    if ($urandom_range(7) == 0) t = $urandom_range(1) ? '1 : '0;
    add_reading(rh, t);
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (readings_taken != readings_queued || expected_conversions.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_LIN_OFFSET:   coef_offset = value[OFFSET_W-1:0];
      REG_LIN_SLOPE:    coef_slope  = value[SLOPE_W-1:0];
      REG_LIN_SQUARE:   coef_square = value[SQUARE_W-1:0];
      REG_TEMP_OFFSET:  temp_zero   = value[TOFF_W-1:0];
      REG_CLAMP_ENABLE: clamp_on    = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_set(longint off, longint slope, longint sq, longint toff, longint clamp);
    write_reg(REG_LIN_OFFSET,   off[CFG_DATA_W-1:0]);
    write_reg(REG_LIN_SLOPE,    slope[CFG_DATA_W-1:0]);
    write_reg(REG_LIN_SQUARE,   sq[CFG_DATA_W-1:0]);
    write_reg(REG_TEMP_OFFSET,  toff[CFG_DATA_W-1:0]);
    write_reg(REG_CLAMP_ENABLE, clamp[CFG_DATA_W-1:0]);
    sets_loaded++;
  endtask

  task automatic run_random(int n);
    repeat (n) add_random_reading();
    wait_idle();
  endtask

  initial begin
    #4000000;
    $display("humidity_temperature_linearizer_test: errors");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset coefficients: corners, negative temperature, both clamp limits
    add_reading(0, 0);
    add_reading(4095, 16383);
    add_reading(0, 16383);
    add_reading(4095, 0);
    add_reading(0, 3970);
    add_reading(1, 3969);
    add_reading(2048, 6470);
    add_reading(4095, 6470);
    add_reading(0, 6470);
    add_reading(1000, 5000);
    add_reading(3000, 9000);
    add_reading(2730, 16383);
    add_reading(1365, 0);
    run_random(300);

    // second sensor variant, unclamped
    load_set(-64'sd40000000000, 64'sd405000000, -64'sd28000, 64'sd3960, 0);
    run_random(250);

    load_set(64'sd100000000000, 64'sd1000000000, 0, 0, 0);
    run_random(125);
    load_set(-64'sd100000000000, 0, -64'sd1000000, 64'sd10000, 1);
    run_random(125);

    // rounding ties either side of zero
    load_set(64'sd150000000, 0, 0, 0, 0);
    add_reading(0, 2500);
    add_reading(4095, 2500);
    wait_idle();
    load_set(-64'sd150000000, 0, 0, 0, 0);
    add_reading(0, 2500);
    add_reading(4095, 2500);
    wait_idle();
    load_set(64'sd49999999, 0, 0, 0, 0);
    add_reading(2000, 2500);
    wait_idle();

    // stray index must leave the coefficients alone
    write_reg(REG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
    add_reading(2000, 2500);
    wait_idle();

    repeat (3) begin
      load_set({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom});
      run_random(80);
    end

    repeat (4) begin
      load_set(longint'($urandom_range(0, 200000)) * 64'sd1000000 - 64'sd100000000000,
               longint'($urandom_range(0, 1000000000)),
               -longint'($urandom_range(0, 1000000)),
               longint'($urandom_range(0, 10000)), longint'($urandom_range(1)));
      run_random(80);
    end

    load_set(longint'(OFFSET_RST), longint'(SLOPE_RST), longint'(SQUARE_RST),
             longint'(TOFF_RST), longint'(CLAMP_RST));
    run_random(100);

    repeat (20) @(negedge clk);
    $display("checked %0d conversions across %0d coefficient sets; %0d hit clamp or saturation",
             results_seen, sets_loaded + 1, limited_words);
    if (errors == 0) $display("humidity_temperature_linearizer_test: clean");
    else $display("humidity_temperature_linearizer_test: errors");
    $finish;
  end

endmodule
